[rtl/rufp_pkg.sv]
// Shared types and constants for the radar UART frame parser.
// No dependencies; every rtl file imports this package.
package rufp_pkg;

    // Result codes carried in the master-side tuser
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;
    localparam logic [1:0] KIND_OVFL  = 2'd3;

    // Input beat kinds
    localparam logic EV_BYTE = 1'b0;
    localparam logic EV_TICK = 1'b1;

    // Header and footer words, first byte on the wire in the top byte
    localparam logic [31:0] HDR_DATA = 32'hF4F3F2F1;
    localparam logic [31:0] HDR_ACK  = 32'hFDFCFBFA;
    localparam logic [31:0] FTR_DATA = 32'hF8F7F6F5;
    localparam logic [31:0] FTR_ACK  = 32'h04030201;

    // Frame offsets that the judge reads: bytes 4 to 17
    localparam int PAY_FIRST = 4;
    localparam int PAY_BYTES = 14;

    // Minimum stored length and judged fields
    localparam int MIN_ACK_LEN  = 10;
    localparam int MIN_DATA_LEN = 12;
    localparam int FOOTER_MIN   = 8;
    localparam logic [15:0] DET_LEN_MIN = 16'd11;
    localparam logic [7:0]  RPT_BASIC   = 8'h01;
    localparam logic [7:0]  RPT_ENG     = 8'h02;
    localparam logic [7:0]  ST_MASK     = 8'h03;

    // Config register indexes
    localparam logic REG_GAP_TIMEOUT = 1'b0;
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;

    localparam int OUT_W = 152;

    typedef enum logic {
        PH_HUNT,
        PH_COLLECT
    } phase_t;

    // One finished frame handed from front to back
    typedef struct packed {
        logic [1:0]                 kind;
        logic [PAY_BYTES-1:0][7:0]  pay;
    } judge_t;

endpackage

[rtl/rufp_front.sv]
// Front end: header hunt, frame collection, footer and gap detection.
// Depends on rufp_pkg; feeds judged frames to rufp_queue.
module rufp_front #(
    parameter int FRAME_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              ev_kind,
    input  logic [7:0]        ev_byte,
    input  logic [15:0]       gap_timeout,
    output logic              push,
    output rufp_pkg::judge_t  push_entry
);
    import rufp_pkg::*;

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);

    phase_t phase_reg, phase_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic is_ack_reg, is_ack_next;
    logic [15:0] gap_reg, gap_next;
    logic [3:0][7:0] win_reg, win_next;
    logic [2:0][7:0] tail_reg, tail_next;
    logic [PAY_BYTES-1:0][7:0] pay_reg, pay_next;

    logic [3:0][7:0] win_wr;
    logic [15:0] gap_inc;
    logic gap_expire;
    logic hdr_ack_hit, hdr_data_hit;
    logic [FILL_W-1:0] fill_inc;
    logic full;
    logic ftr_hit;
    logic is_byte;

    assign is_byte = fire && (ev_kind == EV_BYTE);
    assign gap_inc = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 16'd1;
    assign gap_expire = fire && (ev_kind == EV_TICK) && (gap_inc > gap_timeout);
    assign fill_inc = fill_reg + FILL_W'(1);
    assign full = (fill_reg >= FILL_W'(FRAME_BYTES));

    // Place the byte in the header window
    always_comb
    begin
        win_wr = win_reg;
        win_wr[fill_reg[1:0]] = ev_byte;
    end

    assign hdr_ack_hit  = (fill_reg == FILL_W'(3)) &&
                          ({win_wr[0], win_wr[1], win_wr[2], win_wr[3]} == HDR_ACK);
    assign hdr_data_hit = (fill_reg == FILL_W'(3)) &&
                          ({win_wr[0], win_wr[1], win_wr[2], win_wr[3]} == HDR_DATA);

    // Last four bytes against the footer of this frame type
    assign ftr_hit = (fill_inc >= FILL_W'(FOOTER_MIN)) &&
                     ({tail_reg[0], tail_reg[1], tail_reg[2], ev_byte} ==
                      (is_ack_reg ? FTR_ACK : FTR_DATA));

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (gap_expire)
        begin
            phase_next = PH_HUNT;
        end
        else if (is_byte)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (hdr_ack_hit || hdr_data_hit)
                        phase_next = PH_COLLECT;
                end
                PH_COLLECT:
                begin
                    if (full || ftr_hit)
                        phase_next = PH_HUNT;
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // Datapath and result push
    always_comb
    begin
        fill_next   = fill_reg;
        is_ack_next = is_ack_reg;
        gap_next    = gap_reg;
        win_next    = win_reg;
        tail_next   = tail_reg;
        pay_next    = pay_reg;
        push        = 1'b0;
        push_entry.kind = KIND_OVFL;
        if (fire && (ev_kind == EV_TICK))
        begin
            gap_next = gap_inc;
            if (gap_expire)
                fill_next = '0;
        end
        else if (is_byte)
        begin
            gap_next = '0;
            case (phase_reg)
                PH_HUNT:
                begin
                    win_next = win_wr;
                    if (hdr_ack_hit || hdr_data_hit)
                    begin
                        is_ack_next = hdr_ack_hit;
                        fill_next   = fill_inc;
                    end
                    else if (fill_reg == FILL_W'(3))
                    begin
                        // slide the window by one byte
                        win_next[0] = win_wr[1];
                        win_next[1] = win_wr[2];
                        win_next[2] = win_wr[3];
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
                PH_COLLECT:
                begin
                    if (full)
                    begin
                        // drop the byte and report overflow
                        push      = 1'b1;
                        push_entry.kind = KIND_OVFL;
                        fill_next = '0;
                    end
                    else
                    begin
                        for (int k = 0; k < PAY_BYTES; k++)
                        begin
                            if (fill_reg == FILL_W'(k + PAY_FIRST))
                                pay_next[k] = ev_byte;
                        end
                        tail_next[0] = tail_reg[1];
                        tail_next[1] = tail_reg[2];
                        tail_next[2] = ev_byte;
                        fill_next    = fill_inc;
                        if (ftr_hit)
                        begin
                            push      = 1'b1;
                            fill_next = '0;
                            if (is_ack_reg)
                                push_entry.kind = (fill_inc < FILL_W'(MIN_ACK_LEN)) ?
                                                  KIND_SHORT : KIND_ACK;
                            else
                                push_entry.kind = (fill_inc < FILL_W'(MIN_DATA_LEN)) ?
                                                  KIND_SHORT : KIND_DATA;
                        end
                    end
                end
                default: fill_next = '0;
            endcase
        end
        push_entry.pay = pay_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            fill_reg   <= '0;
            is_ack_reg <= 1'b0;
            gap_reg    <= '0;
            win_reg    <= '0;
            pay_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            is_ack_reg <= is_ack_next;
            gap_reg    <= gap_next;
            win_reg    <= win_next;
            pay_reg    <= pay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
    end

    // Results come only from received bytes
    a_push_byte: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> is_byte)
        else $error("push without a byte beat");

    // Collecting always starts past the header
    a_collect_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COLLECT) |-> (fill_reg >= FILL_W'(4)))
        else $error("collecting with fill below header length");

    // A push always returns to hunting with an empty store
    a_push_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (phase_reg == PH_HUNT) && (fill_reg == '0))
        else $error("frame end did not restart the hunt");

endmodule

[rtl/rufp_queue.sv]
// Two-entry queue of judged frames between front and back.
// Depends on rufp_pkg for the entry type.
module rufp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rufp_pkg::judge_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output rufp_pkg::judge_t  head
);
    import rufp_pkg::*;

    judge_t mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[rtl/rufp_back.sv]
// Back end: applies judged frames to the kept target fields and drives results.
// Depends on rufp_pkg; pulls entries from rufp_queue.
module rufp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  rufp_pkg::judge_t              q_head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rufp_pkg::OUT_W-1:0]    out_data,
    output logic [1:0]                    out_kind
);
    import rufp_pkg::*;

    logic [7:0]  st_reg, st_next;
    logic [15:0] mv_reg, mv_next;
    logic [7:0]  me_reg, me_next;
    logic [15:0] sd_reg, sd_next;
    logic [7:0]  se_reg, se_next;
    logic [15:0] det_reg, det_next;
    logic        pres_reg, pres_next;
    logic [16:0] near_reg, near_next;
    logic        valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg, data_next;
    logic [1:0]  kind_reg;

    logic [7:0]  b6, b7, b8, b11, b14;
    logic [15:0] len, mv, sd, det;
    logic [47:0] ack_pay;

    assign len = {q_head.pay[1], q_head.pay[0]};
    assign b6  = q_head.pay[2];
    assign b7  = q_head.pay[3];
    assign b8  = q_head.pay[4];
    assign mv  = {q_head.pay[6], q_head.pay[5]};
    assign b11 = q_head.pay[7];
    assign sd  = {q_head.pay[9], q_head.pay[8]};
    assign b14 = q_head.pay[10];
    assign det = {q_head.pay[12], q_head.pay[11]};
    assign ack_pay = {q_head.pay[13], q_head.pay[12], q_head.pay[11],
                      q_head.pay[10], q_head.pay[9], q_head.pay[8]};

    // Take the next entry when the output register frees up
    assign pop = q_valid && (!valid_reg || out_ready);

    // Update kept fields and format the result
    always_comb
    begin
        st_next   = st_reg;
        mv_next   = mv_reg;
        me_next   = me_reg;
        sd_next   = sd_reg;
        se_next   = se_reg;
        det_next  = det_reg;
        pres_next = pres_reg;
        near_next = near_reg;
        data_next = '0;
        if (q_head.kind == KIND_DATA)
        begin
            st_next = b8;
            if ((b6 == RPT_BASIC) || (b6 == RPT_ENG))
            begin
                mv_next = mv;
                me_next = b11;
                sd_next = sd;
                se_next = b14;
                if (len > DET_LEN_MIN)
                    det_next = det;
                pres_next = ((b8 & ST_MASK) != 8'h00);
                if (b8[1] && (!b8[0] || (sd < mv)))
                    near_next = {1'b0, sd};
                else if (b8[0])
                    near_next = {1'b0, mv};
                else
                    near_next = '1;
            end
            data_next[7:0]   = st_next;
            data_next[8]     = pres_next;
            data_next[25:9]  = near_next;
            data_next[41:26] = mv_next;
            data_next[49:42] = me_next;
            data_next[65:50] = sd_next;
            data_next[73:66] = se_next;
            data_next[89:74] = det_next;
        end
        else if (q_head.kind == KIND_ACK)
        begin
            data_next[97:90]  = b6;
            data_next[98]     = (b7 == 8'h00);
            data_next[146:99] = ack_pay;
        end
        valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= 8'hFF;
            mv_reg    <= '0;
            me_reg    <= '0;
            sd_reg    <= '0;
            se_reg    <= '0;
            det_reg   <= '0;
            pres_reg  <= 1'b0;
            near_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                st_reg   <= st_next;
                mv_reg   <= mv_next;
                me_reg   <= me_next;
                sd_reg   <= sd_next;
                se_reg   <= se_next;
                det_reg  <= det_next;
                pres_reg <= pres_next;
                near_reg <= near_next;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            kind_reg <= q_head.kind;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;

endmodule

[rtl/radar_uart_frame_parser.sv]
// Top level of the radar UART frame parser: stream ports and APB register.
// Depends on rufp_pkg, rufp_front, rufp_queue and rufp_back.
//
// Each input beat is one received byte (tuser 0) or one time tick (tuser 1); the
// parser sustains one beat per cycle while the frame queue is not full. A byte that
// completes a frame footer, or arrives while the frame store is full, yields one
// result beat after a pass through the two-entry frame queue and the registered
// target-field update stage. The slave side stalls only when that queue is full
// because the master side is not taking results. Only frame bytes 4 to 17 are
// kept in registers; the footer is matched on a running window of the last bytes.
// A partial frame is dropped once more ticks than gap_timeout_ticks (APB offset 0,
// reset 100) pass without a byte. There is no clearing pass after reset.
module radar_uart_frame_parser #(
    parameter int FRAME_BYTES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // slave stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] kind
    // master stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] track_state, [8] presence, [25:9] nearest_distance_cm,
    // [41:26] moving_distance_cm, [49:42] moving_energy, [65:50] still_distance_cm,
    // [73:66] still_energy, [89:74] detection_distance_cm, [97:90] ack_command,
    // [98] ack_ok, [146:99] ack_payload, [151:147] zero
    output logic [rufp_pkg::OUT_W-1:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] frame_kind
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rufp_pkg::*;

    logic [15:0] gap_timeout_reg, gap_timeout_next;
    logic fire;
    logic push, pop, q_full, q_valid;
    judge_t push_entry, q_head;

    // Register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAP_TIMEOUT) ? {16'h0000, gap_timeout_reg} : 32'h0;

    always_comb
    begin
        gap_timeout_next = gap_timeout_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_GAP_TIMEOUT))
            gap_timeout_next = pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_timeout_reg <= GAP_TIMEOUT_RST;
        else
            gap_timeout_reg <= gap_timeout_next;
    end

    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    rufp_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ev_kind     (s_tuser),
        .ev_byte     (s_tdata),
        .gap_timeout (gap_timeout_reg),
        .push        (push),
        .push_entry  (push_entry)
    );

    rufp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    rufp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_kind  (m_tuser)
    );

endmodule
